/* src/dte_pkg.sv */
package dte_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned EPOCH_W = 32;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CLOCK_PRESENT = 2'd0,
        REG_YEAR_FLOOR    = 2'd1,
        REG_YEAR_CEILING  = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST   = 12'd2025;
    localparam logic [YEAR_W-1:0] YEAR_CEILING_RST = 12'd2120;

    // year is offset by 400 so that the leap-day counts stay non-negative
    localparam int unsigned YP_W    = 13;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned SOD_W   = 17;
    localparam int unsigned Q100_W  = 6;
    localparam int unsigned BASE_W  = 21;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned TOTAL_W = 38;

    // 146097 for the extra 400 years plus 719469 to reach 1970-01-01 from day 1
    localparam logic [BASE_W-1:0] DAY_BIAS = 21'd865566;
    // floor(x/100) = (x * 5243) >> 19 for every x this block sees
    localparam logic [YP_W-1:0]   RECIP_100 = 13'd5243;
    localparam int unsigned       RECIP_SH  = 19;

    // year offset: 400 plus the year shift caused by month rollover and the
    // March-based year (January and February belong to the year before)
    function automatic logic [YP_W-1:0] month_year_off(input logic [MONTH_W-1:0] m);
        logic [YP_W-1:0] off;
        case (m)
            4'd0, 4'd1, 4'd2: off = 13'd399;
            4'd15:            off = 13'd401;
            default:          off = 13'd400;
        endcase
        return off;
    endfunction

    // days from 1 March to the first of the month
    function automatic logic [DOY_W-1:0] month_doy(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd0:  d = 9'd275;
            4'd1:  d = 9'd306;
            4'd2:  d = 9'd337;
            4'd3:  d = 9'd0;
            4'd4:  d = 9'd31;
            4'd5:  d = 9'd61;
            4'd6:  d = 9'd92;
            4'd7:  d = 9'd122;
            4'd8:  d = 9'd153;
            4'd9:  d = 9'd184;
            4'd10: d = 9'd214;
            4'd11: d = 9'd245;
            4'd12: d = 9'd275;
            4'd13: d = 9'd306;
            4'd14: d = 9'd337;
            4'd15: d = 9'd0;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* src/datetime_to_epoch_core.sv */
// Calendar reading to Unix seconds (UTC, Gregorian leap years).
//
// Input channel: i_valid / o_ready with year, month, day, hour, minute and
// second. Output channel: o_valid / i_ready with epoch seconds (mod 2^32) and
// a flag that is high when the seconds are nonzero. Out-of-range month, day,
// hour, minute or second values roll into the next unit.
// Configuration: APB write/read of clock_present (0x0), year_floor (0x4) and
// year_ceiling (0x8); the result is 0 when no clock is present or the year
// lies outside the window.
//
// Requests pass stages 1 to 4 and the output register. One request is taken
// every cycle while the receiver keeps i_ready high; the whole five-stage line
// moves together, so the rate is set by the output register being drained.
// When the receiver stalls, every stage holds and o_ready falls in the same
// cycle; nothing is lost or repeated. Reset empties the line and loads the
// register reset values (no clock, window 2025 to 2120).
module datetime_to_epoch_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dte_pkg::YEAR_W-1:0]       i_year,
    input  logic [dte_pkg::MONTH_W-1:0]      i_month,
    input  logic [dte_pkg::DAY_W-1:0]        i_day,
    input  logic [dte_pkg::HOUR_W-1:0]       i_hour,
    input  logic [dte_pkg::MIN_W-1:0]        i_minute,
    input  logic [dte_pkg::SEC_W-1:0]        i_second,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dte_pkg::EPOCH_W-1:0]      o_epoch_seconds,
    output logic                             o_time_valid,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dte_pkg::ADDR_W-1:0]       paddr,
    input  logic [dte_pkg::DATA_W-1:0]       pwdata,
    output logic [dte_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    logic                           r_clock_present;
    logic [dte_pkg::YEAR_W-1:0]     r_year_floor;
    logic [dte_pkg::YEAR_W-1:0]     r_year_ceiling;
    dte_pkg::t_reg_idx              reg_idx;
    logic                           wr_en;

    logic                           adv;

    // stage 1
    logic                           r_v1, r_ok1;
    logic [dte_pkg::YP_W-1:0]       r_yp1, n_yp1;
    logic [dte_pkg::DOY_W-1:0]      r_doy1;
    logic [dte_pkg::DAY_W-1:0]      r_day1;
    logic [dte_pkg::SOD_W-1:0]      r_sod1, n_sod1;
    logic                           n_ok1;

    // stage 2
    logic                           r_v2, r_ok2;
    logic [dte_pkg::Q100_W-1:0]     r_q100_2, n_q100_2;
    logic [dte_pkg::BASE_W-1:0]     r_base2, n_base2;
    logic [dte_pkg::SOD_W-1:0]      r_sod2;
    logic [2*dte_pkg::YP_W-1:0]     recip_prod;

    // stage 3
    logic                           r_v3, r_ok3;
    logic signed [dte_pkg::DAYS_W-1:0] r_days3, n_days3;
    logic [dte_pkg::SOD_W-1:0]      r_sod3;

    // stage 4
    logic                           r_v4, r_ok4;
    logic signed [dte_pkg::TOTAL_W-1:0] r_prod4, n_prod4;
    logic [dte_pkg::SOD_W-1:0]      r_sod4;

    // output stage
    logic                           r_ov;
    logic [dte_pkg::EPOCH_W-1:0]    r_epoch, n_epoch;
    logic                           r_tv;
    logic signed [dte_pkg::TOTAL_W-1:0] total;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = dte_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_present <= 1'b0;
            r_year_floor    <= dte_pkg::YEAR_FLOOR_RST;
            r_year_ceiling  <= dte_pkg::YEAR_CEILING_RST;
        end else if (wr_en) begin
            case (reg_idx)
                dte_pkg::REG_CLOCK_PRESENT: r_clock_present <= pwdata[0];
                dte_pkg::REG_YEAR_FLOOR:    r_year_floor    <= pwdata[dte_pkg::YEAR_W-1:0];
                dte_pkg::REG_YEAR_CEILING:  r_year_ceiling  <= pwdata[dte_pkg::YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dte_pkg::REG_CLOCK_PRESENT: prdata = {31'd0, r_clock_present};
            dte_pkg::REG_YEAR_FLOOR:    prdata = {20'd0, r_year_floor};
            dte_pkg::REG_YEAR_CEILING:  prdata = {20'd0, r_year_ceiling};
            default:                    prdata = '0;
        endcase
    end

    // whole line advances when the output register is free or being taken
    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;

    // stage 1: window check, month table, seconds of day
    always_comb begin
        n_ok1 = r_clock_present && (i_year >= r_year_floor) && (i_year <= r_year_ceiling);
        n_yp1 = dte_pkg::YP_W'(i_year) + dte_pkg::month_year_off(i_month);
        n_sod1 = dte_pkg::SOD_W'(i_hour) * dte_pkg::SOD_W'(3600)
               + dte_pkg::SOD_W'(i_minute) * dte_pkg::SOD_W'(60)
               + dte_pkg::SOD_W'(i_second);
    end

    // stage 2: year/100 by reciprocal, linear part of the day count
    always_comb begin
        recip_prod = 26'(r_yp1) * 26'(dte_pkg::RECIP_100);
        n_q100_2   = recip_prod[dte_pkg::RECIP_SH +: dte_pkg::Q100_W];
        n_base2    = dte_pkg::BASE_W'(r_yp1) * dte_pkg::BASE_W'(365)
                   + dte_pkg::BASE_W'(r_yp1 >> 2)
                   + dte_pkg::BASE_W'(r_doy1)
                   + dte_pkg::BASE_W'(r_day1);
    end

    // stage 3: century corrections and epoch bias
    always_comb begin
        n_days3 = $signed({1'b0, r_base2})
                - $signed(dte_pkg::DAYS_W'(r_q100_2))
                + $signed(dte_pkg::DAYS_W'(r_q100_2 >> 2))
                - $signed({1'b0, dte_pkg::DAY_BIAS});
    end

    // stage 4: days to seconds
    assign n_prod4 = dte_pkg::TOTAL_W'(r_days3) * $signed(dte_pkg::TOTAL_W'(86400));

    // output stage: add time of day, drop negative counts and out-of-window requests
    always_comb begin
        total = r_prod4 + $signed(dte_pkg::TOTAL_W'(r_sod4));
        if (r_ok4 && !total[dte_pkg::TOTAL_W-1]) begin
            n_epoch = total[dte_pkg::EPOCH_W-1:0];
        end else begin
            n_epoch = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok1    <= n_ok1;
            r_yp1    <= n_yp1;
            r_doy1   <= dte_pkg::month_doy(i_month);
            r_day1   <= i_day;
            r_sod1   <= n_sod1;

            r_ok2    <= r_ok1;
            r_q100_2 <= n_q100_2;
            r_base2  <= n_base2;
            r_sod2   <= r_sod1;

            r_ok3    <= r_ok2;
            r_days3  <= n_days3;
            r_sod3   <= r_sod2;

            r_ok4    <= r_ok3;
            r_prod4  <= n_prod4;
            r_sod4   <= r_sod3;

            r_epoch  <= n_epoch;
            r_tv     <= (n_epoch != '0);
        end
    end

    assign o_valid         = r_ov;
    assign o_epoch_seconds = r_epoch;
    assign o_time_valid    = r_tv;

endmodule
